// ===== sv/cce_pkg.sv =====
// Shared types and constants for the column convex envelope block.
// Holds the controller/datapath command and status words. No dependencies.
`timescale 1ns / 1ps
package cce_pkg;

  localparam int DEF_CHAIN_DEPTH = 1024;
  localparam int DEF_COORD_BITS  = 14;
  localparam int SQ_BITS         = 28;
  localparam int MODE_BITS       = 2;
  localparam int APB_ADDR_BITS   = 3;
  localparam int APB_DATA_BITS   = 32;
  localparam logic [SQ_BITS-1:0] MAX_SQ_RESET = 28'd2796202;

  // item modes
  localparam logic [MODE_BITS-1:0] MODE_COLUMN = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  // register indexes (paddr[2])
  localparam logic REG_MAX_SQ = 1'b0;
  localparam logic REG_SIDE   = 1'b1;

  // port A read position select
  typedef enum logic [1:0] {
    RA_MID,
    RA_MIDM1,
    RA_RIDX
  } rd_a_sel_t;

  typedef struct packed {
    logic      cap_item;   // latch input word
    logic      clear;      // empty chain, clear overflow
    logic      bot;        // working on the bottom end
    logic      mid_init;   // mid = top end or bottom end
    logic      mid_step;   // walk mid one point inward
    logic      rd_a;
    rd_a_sel_t rd_a_sel;
    logic      rd_b;       // B = mid (bottom) or mid+1 (top)
    logic      mul_en;     // register cross product terms
    logic      sq_en;      // register squared length terms
    logic      trim;       // drop trimmed points unless segment too long
    logic      add_top;
    logic      add_bot;
    logic      push_use_bot;
    logic      load_out;
  } cce_cmd_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 rvalid;
    logic                 count_zero;
    logic                 seed_two;
    logic                 hit;
    logic                 end_beyond;
    logic                 loop_ok;
    logic                 concave;
    logic                 out_free;
  } cce_stat_t;

endpackage

// ===== sv/cce_ctrl.sv =====
// Controller state machine for the column convex envelope.
// Sequences seeding, end trims, pushes, reads and clears; uses cce_pkg.
`timescale 1ns / 1ps
module cce_ctrl import cce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  cce_stat_t stat,
  output cce_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SEED1, S_SEED2, S_INIT, S_RD_END, S_CMP_END,
    S_LOOP, S_MUL, S_SGN, S_LEN, S_SQ, S_CHK, S_PUSH, S_RD_PT, S_CLEAR,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   bot, bot_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    bot_next   = bot;
    cmd        = '0;
    cmd.bot    = bot;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        bot_next = 1'b0;
        case (stat.mode)
          MODE_COLUMN: begin
            if (!stat.rvalid) state_next = S_FINISH;
            else if (stat.count_zero) state_next = S_SEED1;
            else state_next = S_INIT;
          end
          MODE_READ:  state_next = stat.hit ? S_RD_PT : S_FINISH;
          MODE_CLEAR: state_next = S_CLEAR;
          default:    state_next = S_FINISH;
        endcase
      end
      S_SEED1: begin
        cmd.add_bot = 1'b1;
        state_next  = stat.seed_two ? S_SEED2 : S_FINISH;
      end
      S_SEED2: begin
        cmd.add_bot      = 1'b1;
        cmd.push_use_bot = 1'b1;
        state_next       = S_FINISH;
      end
      S_INIT: begin
        cmd.mid_init = 1'b1;
        state_next   = S_RD_END;
      end
      S_RD_END: begin
        cmd.rd_a     = 1'b1;
        cmd.rd_a_sel = RA_MID;
        state_next   = S_CMP_END;
      end
      S_CMP_END: begin
        if (stat.end_beyond) state_next = S_LOOP;
        else if (bot) state_next = S_FINISH;
        else begin
          bot_next   = 1'b1;
          state_next = S_INIT;
        end
      end
      S_LOOP: begin
        if (stat.loop_ok) begin
          cmd.rd_a     = 1'b1;
          cmd.rd_a_sel = bot ? RA_MIDM1 : RA_MID;
          cmd.rd_b     = 1'b1;
          state_next   = S_MUL;
        end else begin
          state_next = S_LEN;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SGN;
      end
      S_SGN: begin
        if (stat.concave) begin
          cmd.mid_step = 1'b1;
          state_next   = S_LOOP;
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.rd_a     = 1'b1;
        cmd.rd_a_sel = RA_MID;
        state_next   = S_SQ;
      end
      S_SQ: begin
        cmd.sq_en  = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.trim   = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.add_top      = !bot;
        cmd.add_bot      = bot;
        cmd.push_use_bot = bot;
        if (bot) state_next = S_FINISH;
        else begin
          bot_next   = 1'b1;
          state_next = S_INIT;
        end
      end
      S_RD_PT: begin
        cmd.rd_a     = 1'b1;
        cmd.rd_a_sel = RA_RIDX;
        state_next   = S_FINISH;
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bot   <= 1'b0;
    end else begin
      state <= state_next;
      bot   <= bot_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== sv/cce_datapath.sv =====
// Datapath for the column convex envelope: chain memory, head/count,
// cross product and segment length units, output register. Uses cce_pkg.
`timescale 1ns / 1ps
module cce_datapath import cce_pkg::*; #(
  parameter int CHAIN_DEPTH = DEF_CHAIN_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  localparam int IDX = $clog2(CHAIN_DEPTH),
  localparam int CNT = $clog2(CHAIN_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cce_cmd_t              cmd,
  output cce_stat_t             stat,
  input  logic [SQ_BITS-1:0]    max_sq,
  input  logic                  side,
  input  logic [MODE_BITS-1:0]  mode,
  input  logic [COORD_BITS-1:0] column_x,
  input  logic [COORD_BITS-1:0] range_top,
  input  logic [COORD_BITS-1:0] range_bottom,
  input  logic                  range_valid,
  input  logic [IDX-1:0]        read_index,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [CNT-1:0]        path_length,
  output logic                  overflow,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y,
  output logic                  point_valid
);

  localparam int W    = COORD_BITS;
  localparam int PW   = 2 * W + 2;
  localparam int SUMW = 2 * W + 3;
  localparam int CMPW = (SUMW > SQ_BITS) ? SUMW : SQ_BITS;
  localparam logic [CNT:0]   DEPTH_S = (CNT + 1)'(CHAIN_DEPTH);
  localparam logic [CNT-1:0] DEPTH_C = CNT'(CHAIN_DEPTH);
  localparam logic [IDX-1:0] LAST_I  = IDX'(CHAIN_DEPTH - 1);

  // chain storage, {x, y} per entry
  logic [2*W-1:0] mem [CHAIN_DEPTH];
  logic [2*W-1:0] rd_a_data, rd_b_data;

  logic [IDX-1:0] head;
  logic [CNT-1:0] count, mid;
  logic           ovf;

  // latched item
  logic [MODE_BITS-1:0] mode_q;
  logic [W-1:0]         nx, ntop, nbot;
  logic                 rvalid_q, hit_q;
  logic [IDX-1:0]       ridx_q;

  logic signed [PW-1:0] prod1, prod2;
  logic [PW-1:0]        sqx, sqy;

  // circular slot of a chain position
  function automatic logic [IDX-1:0] slot(input logic [IDX-1:0] h,
                                          input logic [CNT-1:0] pos);
    logic [CNT:0] s;
    s = (CNT + 1)'(h) + (CNT + 1)'(pos);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[IDX-1:0];
  endfunction

  logic [IDX-1:0] addr_a, addr_b, addr_w, head_m1;
  logic [W-1:0]   ax, ay, bx, by, ny;
  logic           wr_en;

  assign ax = rd_a_data[2*W-1:W];
  assign ay = rd_a_data[W-1:0];
  assign bx = rd_b_data[2*W-1:W];
  assign by = rd_b_data[W-1:0];
  assign ny = cmd.bot ? nbot : ntop;
  assign head_m1 = (head == '0) ? LAST_I : head - 1'b1;

  always_comb begin
    case (cmd.rd_a_sel)
      RA_MID:   addr_a = slot(head, mid);
      RA_MIDM1: addr_a = slot(head, mid - 1'b1);
      RA_RIDX:  addr_a = slot(head, CNT'(ridx_q));
      default:  addr_a = slot(head, mid);
    endcase
  end
  assign addr_b = cmd.bot ? slot(head, mid) : slot(head, mid + 1'b1);

  // push target
  assign wr_en  = (cmd.add_top || cmd.add_bot) && (count != DEPTH_C);
  assign addr_w = cmd.add_top ? head_m1 : slot(head, count);

  // memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_w] <= {nx, cmd.push_use_bot ? nbot : ntop};
    if (cmd.rd_a) rd_a_data <= mem[addr_a];
    if (cmd.rd_b) rd_b_data <= mem[addr_b];
  end

  // cross product terms: t, m, q are (n, A, B) on top, (A, B, n) on bottom
  logic signed [W:0] tx, ty, mx, my, qx, qy, d1, d2, d3, d4;
  always_comb begin
    if (cmd.bot) begin
      tx = signed'({1'b0, ax}); ty = signed'({1'b0, ay});
      mx = signed'({1'b0, bx}); my = signed'({1'b0, by});
      qx = signed'({1'b0, nx}); qy = signed'({1'b0, nbot});
    end else begin
      tx = signed'({1'b0, nx}); ty = signed'({1'b0, ntop});
      mx = signed'({1'b0, ax}); my = signed'({1'b0, ay});
      qx = signed'({1'b0, bx}); qy = signed'({1'b0, by});
    end
    d1 = mx - tx;
    d2 = qy - my;
    d3 = qx - mx;
    d4 = my - ty;
  end

  // segment length terms, from new point to A
  logic signed [W:0] dx, dy;
  assign dx = signed'({1'b0, nx}) - signed'({1'b0, ax});
  assign dy = signed'({1'b0, ny}) - signed'({1'b0, ay});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod1 <= d1 * d2;
      prod2 <= d3 * d4;
    end
    if (cmd.sq_en) begin
      sqx <= PW'(dx * dx);
      sqy <= PW'(dy * dy);
    end
  end

  logic signed [PW:0] cz;
  logic [SUMW-1:0]    len_sq;
  logic               too_long;
  assign cz       = (PW + 1)'(prod1) - (PW + 1)'(prod2);
  assign len_sq   = SUMW'(sqx) + SUMW'(sqy);
  assign too_long = CMPW'(len_sq) > CMPW'(max_sq);

  // chain pointers and item latch
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.clear) begin
        head  <= '0;
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.trim && !too_long) begin
        if (cmd.bot) count <= mid + 1'b1;
        else begin
          head  <= slot(head, mid);
          count <= count - mid;
        end
      end
      if (cmd.add_top || cmd.add_bot) begin
        if (count == DEPTH_C) ovf <= 1'b1;
        else begin
          count <= count + 1'b1;
          if (cmd.add_top) head <= head_m1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      mode_q   <= mode;
      nx       <= column_x;
      ntop     <= range_top;
      nbot     <= range_bottom;
      rvalid_q <= range_valid;
      ridx_q   <= read_index;
      hit_q    <= (mode == MODE_READ) && (CNT'(read_index) < count);
    end
    if (cmd.mid_init) mid <= cmd.bot ? count - 1'b1 : '0;
    else if (cmd.mid_step) mid <= cmd.bot ? mid - 1'b1 : mid + 1'b1;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      path_length <= count;
      overflow    <= ovf;
      point_valid <= hit_q;
      point_x     <= hit_q ? ax : '0;
      point_y     <= hit_q ? ay : '0;
    end
  end

  // status to controller
  always_comb begin
    stat.mode       = mode_q;
    stat.rvalid     = rvalid_q;
    stat.count_zero = (count == '0);
    stat.seed_two   = (ntop != nbot);
    stat.hit        = hit_q;
    stat.end_beyond = cmd.bot ? (nbot > ay) : (ntop < ay);
    stat.loop_ok    = cmd.bot ? (mid != '0)
                              : ((CNT + 1)'(mid) + 1'b1 < (CNT + 1)'(count));
    stat.concave    = side ? (cz < 0) : (cz > 0);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

// ===== sv/column_convex_envelope.sv =====
// Column convex envelope: one result word per input word.
// Status, missed-read and empty-column words go straight to the result; read hits
// and clears do a memory read or a clear first, a seeding column one or two pushes,
// and any other column the end checks and trim walk through the chain memory.
// One word in flight; the next is taken the cycle after its result loads.
// Reset clears chain length, head, overflow flag and registers to defaults.
`timescale 1ns / 1ps
module column_convex_envelope import cce_pkg::*; #(
  parameter int CHAIN_DEPTH = DEF_CHAIN_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  localparam int IDX = $clog2(CHAIN_DEPTH),
  localparam int CNT = $clog2(CHAIN_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  // input words
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [MODE_BITS-1:0]     mode,
  input  logic [COORD_BITS-1:0]    column_x,
  input  logic [COORD_BITS-1:0]    range_top,
  input  logic [COORD_BITS-1:0]    range_bottom,
  input  logic                     range_valid,
  input  logic [IDX-1:0]           read_index,
  // result words
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CNT-1:0]           path_length,
  output logic                     overflow,
  output logic [COORD_BITS-1:0]    point_x,
  output logic [COORD_BITS-1:0]    point_y,
  output logic                     point_valid
);

  logic [SQ_BITS-1:0] max_sq;
  logic               side;
  cce_cmd_t           cmd;
  cce_stat_t          stat;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sq <= MAX_SQ_RESET;
      side   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MAX_SQ: max_sq <= pwdata[SQ_BITS-1:0];
        REG_SIDE:   side   <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_SQ: prdata = APB_DATA_BITS'(max_sq);
      REG_SIDE:   prdata = APB_DATA_BITS'(side);
      default:    prdata = '0;
    endcase
  end

  cce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cce_datapath #(
    .CHAIN_DEPTH (CHAIN_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .max_sq       (max_sq),
    .side         (side),
    .mode         (mode),
    .column_x     (column_x),
    .range_top    (range_top),
    .range_bottom (range_bottom),
    .range_valid  (range_valid),
    .read_index   (read_index),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .path_length  (path_length),
    .overflow     (overflow),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_valid  (point_valid)
  );

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (path_length <= CNT'(CHAIN_DEPTH)))
    else $error("chain length above depth");

  a_point_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !point_valid) |-> (point_x == '0 && point_y == '0))
    else $error("point fields set without a valid read");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && point_valid) |-> (path_length != '0))
    else $error("point read from an empty chain");

endmodule
